[design/i2cbs_pkg.sv]
// Package with command codes, microcode word layout and the control program ROM.
`timescale 1ns / 1ps
package i2cbs_pkg;

	localparam int BITS_PER_BYTE = 8;
	localparam int CNT_W = $clog2(BITS_PER_BYTE);
	localparam int PC_W = 5;

	localparam logic [2:0] ACT_START    = 3'd0;
	localparam logic [2:0] ACT_STOP     = 3'd1;
	localparam logic [2:0] ACT_WRITE    = 3'd2;
	localparam logic [2:0] ACT_READ     = 3'd3;
	localparam logic [2:0] ACT_SEND_ACK = 3'd4;
	localparam logic [2:0] ACT_RECV_ACK = 3'd5;

	// Entry points of the routines in the control program.
	localparam logic [PC_W-1:0] PC_START    = 5'd0;
	localparam logic [PC_W-1:0] PC_STOP     = 5'd4;
	localparam logic [PC_W-1:0] PC_WRITE    = 5'd7;
	localparam logic [PC_W-1:0] PC_READ     = 5'd10;
	localparam logic [PC_W-1:0] PC_READ_BIT = 5'd11;
	localparam logic [PC_W-1:0] PC_SEND_ACK = 5'd13;
	localparam logic [PC_W-1:0] PC_RECV_ACK = 5'd16;

	typedef enum logic {
		PIN_SCL,
		PIN_SDA
	} pin_t;

	typedef enum logic [1:0] {
		SRC_ZERO,
		SRC_ONE,
		SRC_TX_BIT,
		SRC_ACK
	} src_t;

	// One control word: which pin is written and with what, plus side effects.
	typedef struct packed {
		pin_t            pin;
		src_t            src;
		logic            sample;
		logic            shift;
		logic            loop;
		logic [PC_W-1:0] target;
		logic            fin;
		logic            rd_out;
		logic            ack_out;
	} uword_t;

	typedef struct packed {
		logic       clock_line;
		logic       data_line;
		logic [7:0] read_value;
		logic       ack_seen;
		logic       last;
	} beat_t;

	function automatic uword_t mk_uword(input pin_t pin, input src_t src, input logic sample,
		input logic shift, input logic loop, input logic [PC_W-1:0] target, input logic fin,
		input logic rd_out, input logic ack_out);
		uword_t w;
		w.pin = pin;
		w.src = src;
		w.sample = sample;
		w.shift = shift;
		w.loop = loop;
		w.target = target;
		w.fin = fin;
		w.rd_out = rd_out;
		w.ack_out = ack_out;
		return w;
	endfunction

	// The control program. A loop step jumps back to its target until the bit
	// counter reaches the last bit, and then ends the command.
	function automatic uword_t ucode(input logic [PC_W-1:0] pc);
		uword_t w;
		w = mk_uword(PIN_SCL, SRC_ZERO, 1'b0, 1'b0, 1'b0, PC_START, 1'b1, 1'b0, 1'b0);
		unique case (pc)
			// start
			5'd0:  w = mk_uword(PIN_SDA, SRC_ONE, 1'b0, 1'b0, 1'b0, PC_START, 1'b0, 1'b0, 1'b0);
			5'd1:  w = mk_uword(PIN_SCL, SRC_ONE, 1'b0, 1'b0, 1'b0, PC_START, 1'b0, 1'b0, 1'b0);
			5'd2:  w = mk_uword(PIN_SDA, SRC_ZERO, 1'b0, 1'b0, 1'b0, PC_START, 1'b0, 1'b0, 1'b0);
			5'd3:  w = mk_uword(PIN_SCL, SRC_ZERO, 1'b0, 1'b0, 1'b0, PC_START, 1'b1, 1'b0, 1'b0);
			// stop
			5'd4:  w = mk_uword(PIN_SDA, SRC_ZERO, 1'b0, 1'b0, 1'b0, PC_START, 1'b0, 1'b0, 1'b0);
			5'd5:  w = mk_uword(PIN_SCL, SRC_ONE, 1'b0, 1'b0, 1'b0, PC_START, 1'b0, 1'b0, 1'b0);
			5'd6:  w = mk_uword(PIN_SDA, SRC_ONE, 1'b0, 1'b0, 1'b0, PC_START, 1'b1, 1'b0, 1'b0);
			// write byte
			5'd7:  w = mk_uword(PIN_SDA, SRC_TX_BIT, 1'b0, 1'b0, 1'b0, PC_START, 1'b0, 1'b0, 1'b0);
			5'd8:  w = mk_uword(PIN_SCL, SRC_ONE, 1'b0, 1'b0, 1'b0, PC_START, 1'b0, 1'b0, 1'b0);
			5'd9:  w = mk_uword(PIN_SCL, SRC_ZERO, 1'b0, 1'b1, 1'b1, PC_WRITE, 1'b1, 1'b0, 1'b0);
			// read byte
			5'd10: w = mk_uword(PIN_SDA, SRC_ONE, 1'b0, 1'b0, 1'b0, PC_START, 1'b0, 1'b0, 1'b0);
			5'd11: w = mk_uword(PIN_SCL, SRC_ONE, 1'b1, 1'b0, 1'b0, PC_START, 1'b0, 1'b0, 1'b0);
			5'd12: w = mk_uword(PIN_SCL, SRC_ZERO, 1'b0, 1'b1, 1'b1, PC_READ_BIT, 1'b1, 1'b1,
				1'b0);
			// send acknowledge
			5'd13: w = mk_uword(PIN_SDA, SRC_ACK, 1'b0, 1'b0, 1'b0, PC_START, 1'b0, 1'b0, 1'b0);
			5'd14: w = mk_uword(PIN_SCL, SRC_ONE, 1'b0, 1'b0, 1'b0, PC_START, 1'b0, 1'b0, 1'b0);
			5'd15: w = mk_uword(PIN_SCL, SRC_ZERO, 1'b0, 1'b0, 1'b0, PC_START, 1'b1, 1'b0, 1'b0);
			// receive acknowledge
			5'd16: w = mk_uword(PIN_SDA, SRC_ONE, 1'b0, 1'b0, 1'b0, PC_START, 1'b0, 1'b0, 1'b0);
			5'd17: w = mk_uword(PIN_SCL, SRC_ONE, 1'b1, 1'b0, 1'b0, PC_START, 1'b0, 1'b0, 1'b0);
			5'd18: w = mk_uword(PIN_SCL, SRC_ZERO, 1'b0, 1'b0, 1'b0, PC_START, 1'b1, 1'b0, 1'b1);
			default: w = mk_uword(PIN_SCL, SRC_ZERO, 1'b0, 1'b0, 1'b0, PC_START, 1'b1, 1'b0,
				1'b0);
		endcase
		return w;
	endfunction

endpackage

[design/i2cbs_if.sv]
// Handshake interfaces for the command channel and the pin write channel.
`timescale 1ns / 1ps
interface i2cbs_cmd_if;
	logic       valid;
	logic       ready;
	logic [2:0] action;
	logic [7:0] write_byte;
	logic       ack_bit;
	logic [7:0] line_samples;

	modport source (output valid, output action, output write_byte, output ack_bit,
		output line_samples, input ready);
	modport sink (input valid, input action, input write_byte, input ack_bit,
		input line_samples, output ready);
endinterface

interface i2cbs_beat_if;
	logic       valid;
	logic       ready;
	logic       clock_line;
	logic       data_line;
	logic [7:0] read_value;
	logic       ack_seen;
	logic       last;

	modport source (output valid, output clock_line, output data_line, output read_value,
		output ack_seen, output last, input ready);
	modport sink (input valid, input clock_line, input data_line, input read_value,
		input ack_seen, input last, output ready);
endinterface

[design/i2cbs_pin_datapath.sv]
// Datapath driven by the control word: line levels, shift registers and bit counter.
`timescale 1ns / 1ps
module i2cbs_pin_datapath
	import i2cbs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  logic [7:0] write_byte,
	input  logic       ack_bit,
	input  logic [7:0] line_samples,
	input  logic       step,
	input  uword_t     uw,
	output beat_t      beat,
	output logic       cnt_done
);

	logic             scl_q;
	logic             sda_q;
	logic [7:0]       tx_q;
	logic [7:0]       samp_q;
	logic [7:0]       acc_q;
	logic             ack_q;
	logic [CNT_W-1:0] cnt_q;
	logic             val;
	logic             scl_nx;
	logic             sda_nx;
	logic             last;

	assign cnt_done = (cnt_q == CNT_W'(BITS_PER_BYTE - 1));

	always_comb begin
		unique case (uw.src)
			SRC_ZERO:   val = 1'b0;
			SRC_ONE:    val = 1'b1;
			SRC_TX_BIT: val = tx_q[7];
			SRC_ACK:    val = ack_q;
			default:    val = 1'b1;
		endcase
	end

	assign scl_nx = (uw.pin == PIN_SCL) ? val : scl_q;
	assign sda_nx = (uw.pin == PIN_SDA) ? val : sda_q;
	assign last = uw.fin & (~uw.loop | cnt_done);

	assign beat.clock_line = scl_nx;
	assign beat.data_line = sda_nx;
	assign beat.read_value = (last & uw.rd_out) ? acc_q : 8'd0;
	assign beat.ack_seen = last & uw.ack_out & acc_q[0];
	assign beat.last = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scl_q <= 1'b1;
			sda_q <= 1'b1;
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= '0;
		end else if (step) begin
			scl_q <= scl_nx;
			sda_q <= sda_nx;
			if (uw.shift) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// Sampled levels enter the accumulator MSB first, one per clock high.
	always_ff @(posedge clk) begin
		if (load) begin
			tx_q <= write_byte;
			samp_q <= line_samples;
			ack_q <= ack_bit;
			acc_q <= 8'd0;
		end else if (step) begin
			if (uw.sample) begin
				acc_q <= {acc_q[6:0], samp_q[7]};
				samp_q <= {samp_q[6:0], 1'b0};
			end
			if (uw.shift) begin
				tx_q <= {tx_q[6:0], 1'b0};
			end
		end
	end

endmodule

[design/i2c_master_bit_sequencer.sv]
// Top level of the microcoded I2C master bit sequencer.
//
// Usage: the cmd channel takes one I2C master command per beat (start, stop,
// write byte, read byte, send acknowledge, receive acknowledge). The beat
// channel returns one beat per pin write with both line levels; the final
// beat of a command has last set and, for read byte or receive acknowledge,
// the assembled byte or the sampled acknowledge level.
// Beats per command: start 4, stop 3, write byte 24, read byte 17, send and
// receive acknowledge 3 each. Action codes 6 and 7 are taken and dropped.
// The program counter walks a microcode ROM at one step per cycle while the
// output register is free; an accepted command first loads the program
// counter, and each step then registers its beat in the output register; a new
// command is taken in the cycle after the final beat has been generated.
// Each step writes into an output register; while the receiver holds ready
// low the register holds its beat and the sequencer waits.
// Reset leaves both lines high (released) and the sequencer idle.
`timescale 1ns / 1ps
module i2c_master_bit_sequencer
	import i2cbs_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	i2cbs_cmd_if.sink    cmd,
	i2cbs_beat_if.source beat
);

	logic            busy_q;
	logic [PC_W-1:0] pc_q;
	logic            out_valid_q;
	beat_t           beat_q;
	logic            accept;
	logic            step;
	logic            entry_ok;
	logic [PC_W-1:0] entry_pc;
	logic            cnt_done;
	uword_t          uw;
	beat_t           dp_beat;

	assign cmd.ready = ~busy_q;
	assign accept = cmd.valid & ~busy_q;
	assign step = busy_q & (~out_valid_q | beat.ready);
	assign uw = ucode(pc_q);

	always_comb begin
		entry_ok = 1'b1;
		entry_pc = PC_START;
		unique case (cmd.action)
			ACT_START:    entry_pc = PC_START;
			ACT_STOP:     entry_pc = PC_STOP;
			ACT_WRITE:    entry_pc = PC_WRITE;
			ACT_READ:     entry_pc = PC_READ;
			ACT_SEND_ACK: entry_pc = PC_SEND_ACK;
			ACT_RECV_ACK: entry_pc = PC_RECV_ACK;
			default:      entry_ok = 1'b0;
		endcase
	end

	i2cbs_pin_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (accept),
		.write_byte   (cmd.write_byte),
		.ack_bit      (cmd.ack_bit),
		.line_samples (cmd.line_samples),
		.step         (step),
		.uw           (uw),
		.beat         (dp_beat),
		.cnt_done     (cnt_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q <= PC_START;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= entry_ok;
				pc_q <= entry_pc;
			end else if (step) begin
				if (dp_beat.last) begin
					busy_q <= 1'b0;
				end else if (uw.loop & ~cnt_done) begin
					pc_q <= uw.target;
				end else begin
					pc_q <= pc_q + PC_W'(1);
				end
			end
			if (step) begin
				out_valid_q <= 1'b1;
			end else if (beat.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			beat_q <= dp_beat;
		end
	end

	assign beat.valid = out_valid_q;
	assign beat.clock_line = beat_q.clock_line;
	assign beat.data_line = beat_q.data_line;
	assign beat.read_value = beat_q.read_value;
	assign beat.ack_seen = beat_q.ack_seen;
	assign beat.last = beat_q.last;

endmodule

[test/testbench.sv]
// Self-checking testbench for the I2C master bit sequencer: directed and random commands.
`timescale 1ns / 1ps
module testbench;
	import i2cbs_pkg::*;

	// Action codes that the block takes and drops without any pin write.
	localparam logic [2:0] ACT_SPARE_A = 3'd6;
	localparam logic [2:0] ACT_SPARE_B = 3'd7;
	localparam int QUIET_LIMIT = 2000;
	localparam int TAIL_CYCLES = 6;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	i2cbs_cmd_if cmd ();
	i2cbs_beat_if beat ();

	i2c_master_bit_sequencer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.beat   (beat)
	);

	always #5 clk = ~clk;

	// Line levels as the predictor sees them, and the pin writes still to come.
	logic scl_level;
	logic sda_level;
	beat_t pin_writes_due[$];
	int mismatches = 0;
	int commands_sent = 0;
	int quiet_cycles = 0;
	bit steady = 1'b0;
	int ready_hold = 0;

	initial begin
		cmd.valid = 1'b0;
		cmd.action = ACT_START;
		cmd.write_byte = '0;
		cmd.ack_bit = 1'b0;
		cmd.line_samples = '0;
		beat.ready = 1'b0;
		scl_level = 1'b1;
		sda_level = 1'b1;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic report_error(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s", $realtime, msg);
	endtask

	task automatic push_write(input logic scl, input logic sda);
		beat_t b;
		b = '0;
		scl_level = scl;
		sda_level = sda;
		b.clock_line = scl;
		b.data_line = sda;
		pin_writes_due.push_back(b);
	endtask

	// Expands one accepted command into the pin writes that the block is expected to make.
	task automatic plan_pin_writes(input logic [2:0] act, input logic [7:0] wbyte,
		input logic ack, input logic [7:0] samples);
		beat_t tail;
		int idx;
		case (act)
			ACT_START: begin
				push_write(scl_level, 1'b1);
				push_write(1'b1, sda_level);
				push_write(scl_level, 1'b0);
				push_write(1'b0, sda_level);
			end
			ACT_STOP: begin
				push_write(scl_level, 1'b0);
				push_write(1'b1, sda_level);
				push_write(scl_level, 1'b1);
			end
			ACT_WRITE: begin
				for (int i = BITS_PER_BYTE - 1; i >= 0; i--) begin
					push_write(scl_level, wbyte[i]);
					push_write(1'b1, sda_level);
					push_write(1'b0, sda_level);
				end
			end
			ACT_READ: begin
				push_write(scl_level, 1'b1);
				for (int i = 0; i < BITS_PER_BYTE; i++) begin
					push_write(1'b1, sda_level);
					push_write(1'b0, sda_level);
				end
			end
			ACT_SEND_ACK: begin
				push_write(scl_level, ack);
				push_write(1'b1, sda_level);
				push_write(1'b0, sda_level);
			end
			ACT_RECV_ACK: begin
				push_write(scl_level, 1'b1);
				push_write(1'b1, sda_level);
				push_write(1'b0, sda_level);
			end
			default: return;
		endcase
		idx = pin_writes_due.size() - 1;
		tail = pin_writes_due[idx];
		tail.last = 1'b1;
		if (act == ACT_READ)
			tail.read_value = samples;
		if (act == ACT_RECV_ACK)
			tail.ack_seen = samples[7];
		pin_writes_due[idx] = tail;
	endtask

	always @(posedge clk) begin
		if (arst_n && cmd.valid && cmd.ready)
			plan_pin_writes(cmd.action, cmd.write_byte, cmd.ack_bit, cmd.line_samples);
	end

	always @(posedge clk) begin
		beat_t got;
		beat_t want;
		if (arst_n && beat.valid && beat.ready) begin
			got.clock_line = beat.clock_line;
			got.data_line = beat.data_line;
			got.read_value = beat.read_value;
			got.ack_seen = beat.ack_seen;
			got.last = beat.last;
			if (pin_writes_due.size() == 0) begin
				report_error($sformatf("unexpected beat scl=%0b sda=%0b rd=%02h ack=%0b last=%0b",
					got.clock_line, got.data_line, got.read_value, got.ack_seen, got.last));
			end else begin
				want = pin_writes_due.pop_front();
				if (got !== want)
					report_error($sformatf({"mismatch: expected scl=%0b sda=%0b rd=%02h ack=%0b ",
						"last=%0b, got scl=%0b sda=%0b rd=%02h ack=%0b last=%0b"},
						want.clock_line, want.data_line, want.read_value, want.ack_seen,
						want.last, got.clock_line, got.data_line, got.read_value,
						got.ack_seen, got.last));
			end
		end
	end

	// The receiver stalls at random, beat by beat.
	always @(posedge clk) begin
		if (!arst_n) begin
			beat.ready <= 1'b0;
		end else if (ready_hold > 0) begin
			ready_hold--;
			beat.ready <= 1'b0;
		end else begin
			ready_hold = pick_gap();
			beat.ready <= (ready_hold == 0);
			if (ready_hold > 0)
				ready_hold--;
		end
	end

	always @(posedge clk) begin
		if ((cmd.valid && cmd.ready) || (beat.valid && beat.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[i2c_master_bit_sequencer] ERROR");
			$finish;
		end
	end

	// Called at a rising edge; returns at the edge where the beat is accepted.
	task automatic send_cmd(input logic [2:0] act, input logic [7:0] wbyte, input logic ack,
		input logic [7:0] samples);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			cmd.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.action <= act;
		cmd.write_byte <= wbyte;
		cmd.ack_bit <= ack;
		cmd.line_samples <= samples;
		do @(posedge clk); while (!cmd.ready);
		if (act <= ACT_RECV_ACK)
			commands_sent++;
	endtask

	task automatic send_random(input logic [2:0] act);
		send_cmd(act, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
			8'($urandom_range(0, 255)));
	endtask

	// Holds the command channel until every predicted pin write has come back.
	task automatic drain();
		cmd.valid <= 1'b0;
		do @(posedge clk); while (pin_writes_due.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic test_directed_transfers();
		send_cmd(ACT_STOP, 8'h00, 1'b0, 8'h00);
		send_cmd(ACT_START, 8'h00, 1'b0, 8'h00);
		send_cmd(ACT_WRITE, 8'h00, 1'b0, 8'hFF);
		send_cmd(ACT_RECV_ACK, 8'hFF, 1'b1, 8'h80);
		send_cmd(ACT_WRITE, 8'hFF, 1'b1, 8'h00);
		send_cmd(ACT_RECV_ACK, 8'h00, 1'b0, 8'h7F);
		send_cmd(ACT_READ, 8'h00, 1'b0, 8'hFF);
		send_cmd(ACT_SEND_ACK, 8'hFF, 1'b0, 8'hFF);
		send_cmd(ACT_READ, 8'hFF, 1'b1, 8'h00);
		send_cmd(ACT_SEND_ACK, 8'h00, 1'b1, 8'h00);
		send_cmd(ACT_STOP, 8'hFF, 1'b1, 8'hFF);
		send_cmd(ACT_STOP, 8'h00, 1'b0, 8'h00);
		drain();
	endtask

	// A start in the middle of a transfer must not put a stop on the bus first.
	task automatic test_repeated_start();
		send_cmd(ACT_START, 8'h00, 1'b0, 8'h00);
		send_cmd(ACT_WRITE, 8'hA5, 1'b0, 8'h5A);
		send_cmd(ACT_RECV_ACK, 8'h00, 1'b0, 8'h00);
		send_cmd(ACT_START, 8'h00, 1'b0, 8'h00);
		send_cmd(ACT_START, 8'hFF, 1'b1, 8'hFF);
		send_cmd(ACT_READ, 8'h00, 1'b0, 8'h5A);
		send_cmd(ACT_SEND_ACK, 8'h00, 1'b1, 8'h00);
		send_cmd(ACT_STOP, 8'h00, 1'b0, 8'h00);
		drain();
	endtask

	task automatic test_unused_codes();
		send_cmd(ACT_SPARE_A, 8'hFF, 1'b1, 8'hFF);
		send_cmd(ACT_START, 8'h00, 1'b0, 8'h00);
		send_cmd(ACT_SPARE_B, 8'h00, 1'b0, 8'h00);
		send_cmd(ACT_SPARE_A, 8'h3C, 1'b0, 8'hC3);
		send_cmd(ACT_STOP, 8'h00, 1'b0, 8'h00);
		drain();
	endtask

	// One well-formed transfer: address, acknowledge, a few bytes, then a stop
	// or a repeated start.
	task automatic send_transfer();
		bit reading;
		int nbytes;
		reading = 1'($urandom_range(0, 1));
		nbytes = $urandom_range(1, 4);
		send_random(ACT_START);
		send_random(ACT_WRITE);
		send_random(ACT_RECV_ACK);
		for (int i = 0; i < nbytes; i++) begin
			if (reading) begin
				send_random(ACT_READ);
				send_random(ACT_SEND_ACK);
			end else begin
				send_random(ACT_WRITE);
				send_random(ACT_RECV_ACK);
			end
		end
		if ($urandom_range(0, 3) != 0)
			send_random(ACT_STOP);
	endtask

	task automatic test_random_traffic(input int target);
		int stop_at;
		stop_at = commands_sent + target;
		while (commands_sent < stop_at) begin
			if ($urandom_range(0, 99) < 15)
				send_random(3'($urandom_range(0, 7)));
			else
				send_transfer();
			if ($urandom_range(0, 7) == 0)
				drain();
		end
		drain();
	endtask

	task automatic test_back_to_back();
		steady = 1'b1;
		repeat (3) send_transfer();
		drain();
		steady = 1'b0;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_transfers();
		test_repeated_start();
		test_unused_codes();
		test_back_to_back();
		test_random_traffic(400);
		if (mismatches == 0 && pin_writes_due.size() == 0)
			$display("[i2c_master_bit_sequencer] OK");
		else
			$display("[i2c_master_bit_sequencer] ERROR");
		$finish;
	end

endmodule

[files.f]
design/i2cbs_pkg.sv
design/i2cbs_if.sv
design/i2cbs_pin_datapath.sv
design/i2c_master_bit_sequencer.sv
test/testbench.sv
